>>> rtl/core/dnsrw_pkg.sv
package dnsrw_pkg;

    localparam int MAX_MESSAGE_BYTES = 4096;
    localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam logic [7:0] PTR_TAG   = 8'hC0;
    localparam int HEADER_BYTES      = 12;
    localparam int RECORD_FIXED      = 10;
    localparam int QUESTION_FIXED    = 4;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_TUSER_W = 2;

    localparam logic [1:0] KIND_QUESTION = 2'd0;
    localparam logic [1:0] KIND_RECORD   = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT_HDR = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [17:0] record_index;
        logic [11:0] name_offset;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [31:0] time_to_live;
        logic [11:0] data_offset;
        logic [15:0] data_length;
        logic [1:0]  status;
        logic        is_last;
    } t_result;

endpackage

>>> rtl/core/dns_record_walker_core.sv
// Channel   Dir  Ports          Transaction payload
// s_axis    in   tdata, tlast   one message byte; tlast marks the final byte
// m_axis    out  tdata, tuser,  one question, record or end-of-message result;
//                tlast          tlast set on the end result
//
// One byte per cycle while the queue has room: the header/name/field walker
// updates from the input register, results go into a four-entry output queue.
// A byte that completes an item and is also the last byte gives two results; the
// input register advances only when the queue has room for two.
// Reset (synchronous, active low) returns the walker to the header phase.
// A stall on m_axis fills the queue, then holds s_axis tready low.
module dns_record_walker_core
    import dnsrw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  logic                   i_s_axis_tlast,  // last_byte
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [17:0] record_index, [29:18] name_offset, [45:30] record_type,
    // [61:46] record_class, [93:62] time_to_live, [105:94] data_offset,
    // [121:106] data_length, [123:122] status, [127:124] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser,  // [1:0] kind
    output logic                   o_m_axis_tlast   // is_last
);

    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_NAME    = 4'd1;
    localparam logic [3:0] PH_POINTER = 4'd2;
    localparam logic [3:0] PH_LABEL   = 4'd3;
    localparam logic [3:0] PH_FIXED   = 4'd4;
    localparam logic [3:0] PH_DATA    = 4'd5;
    localparam logic [3:0] PH_DONE    = 4'd6;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // walker state
    logic [POS_W-1:0] r_pos, n_pos;
    logic [3:0]       r_phase, n_phase;
    logic [15:0]      r_q_left, n_q_left;
    logic [17:0]      r_rec_left, n_rec_left;
    logic [15:0]      r_skip, n_skip;
    logic [3:0]       r_fbi, n_fbi;
    logic [15:0]      r_type, n_type;
    logic [15:0]      r_class, n_class;
    logic [31:0]      r_ttl, n_ttl;
    logic [15:0]      r_len, n_len;
    logic [11:0]      r_name_start, n_name_start;
    logic [17:0]      r_idx, n_idx;
    logic [1:0]       r_err, n_err;

    // output queue
    t_result           r_q_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    logic       w_room, w_advance, w_accept, w_pop;
    logic       w_item_vld, w_end_vld, w_begin;
    t_result    w_item, w_end, w_first;
    logic [1:0] w_push_n;
    logic [15:0] w_len_new;

    assign w_room          = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign w_advance       = r_in_valid && w_room;
    assign o_s_axis_tready = !r_in_valid || w_room;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;
    assign w_len_new       = {r_len[7:0], r_in_byte};

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_q_left     = r_q_left;
        n_rec_left   = r_rec_left;
        n_skip       = r_skip;
        n_fbi        = r_fbi;
        n_type       = r_type;
        n_class      = r_class;
        n_ttl        = r_ttl;
        n_len        = r_len;
        n_name_start = r_name_start;
        n_idx        = r_idx;
        n_err        = r_err;
        w_item_vld   = 1'b0;
        w_end_vld    = 1'b0;
        w_begin      = 1'b0;
        w_item       = '0;
        w_end        = '0;

        if (r_pos >= POS_W'(MAX_MESSAGE_BYTES)) begin
            n_err = ST_TOO_LONG;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_W'(4)) begin
                        n_q_left = {r_in_byte, 8'h00};
                    end else if (r_pos == POS_W'(5)) begin
                        n_q_left = {r_q_left[15:8], r_in_byte};
                    end else if (r_pos == POS_W'(6) || r_pos == POS_W'(8)
                                 || r_pos == POS_W'(10)) begin
                        n_skip = {r_in_byte, 8'h00};
                    end else if (r_pos == POS_W'(7) || r_pos == POS_W'(9)
                                 || r_pos == POS_W'(11)) begin
                        n_rec_left = r_rec_left + {2'b00, r_skip[15:8], r_in_byte};
                        n_skip     = '0;
                    end
                    if (r_pos == POS_W'(HEADER_BYTES - 1)) begin
                        n_idx   = '0;
                        w_begin = 1'b1;
                    end
                end
                PH_NAME: begin
                    if (r_in_byte == 8'h00) begin
                        n_phase = PH_FIXED;
                        n_fbi   = '0;
                    end else if ((r_in_byte & PTR_TAG) == PTR_TAG) begin
                        n_phase = PH_POINTER;
                    end else begin
                        n_skip  = {8'h00, r_in_byte};
                        n_phase = PH_LABEL;
                    end
                end
                PH_POINTER: begin
                    n_phase = PH_FIXED;
                    n_fbi   = '0;
                end
                PH_LABEL: begin
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) begin
                        n_phase = PH_NAME;
                    end
                end
                PH_FIXED: begin
                    case (r_fbi)
                        4'd0: n_type  = {8'h00, r_in_byte};
                        4'd1: n_type  = {r_type[7:0], r_in_byte};
                        4'd2: n_class = {8'h00, r_in_byte};
                        4'd3: n_class = {r_class[7:0], r_in_byte};
                        4'd4: n_ttl   = {24'h0, r_in_byte};
                        4'd5, 4'd6, 4'd7: n_ttl = {r_ttl[23:0], r_in_byte};
                        4'd8: n_len   = {8'h00, r_in_byte};
                        default: n_len = w_len_new;
                    endcase
                    n_fbi = r_fbi + 4'd1;
                    if (r_q_left != '0) begin
                        if (r_fbi == 4'(QUESTION_FIXED - 1)) begin
                            w_item_vld          = 1'b1;
                            w_item.kind         = KIND_QUESTION;
                            w_item.record_index = r_idx;
                            w_item.name_offset  = r_name_start;
                            w_item.record_type  = r_type;
                            w_item.record_class = {r_class[7:0], r_in_byte};
                            n_q_left            = r_q_left - 16'd1;
                            n_idx               = (r_q_left == 16'd1) ? '0 : r_idx + 18'd1;
                            w_begin             = 1'b1;
                        end
                    end else if (r_fbi == 4'(RECORD_FIXED - 1)) begin
                        if (w_len_new == '0) begin
                            w_item_vld          = 1'b1;
                            w_item.kind         = KIND_RECORD;
                            w_item.record_index = r_idx;
                            w_item.name_offset  = r_name_start;
                            w_item.record_type  = r_type;
                            w_item.record_class = r_class;
                            w_item.time_to_live = r_ttl;
                            w_item.data_offset  = r_pos[11:0] + 12'd1;
                            w_item.data_length  = '0;
                            n_rec_left          = r_rec_left - 18'd1;
                            n_idx               = r_idx + 18'd1;
                            w_begin             = 1'b1;
                        end else begin
                            n_skip  = w_len_new;
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) begin
                        w_item_vld          = 1'b1;
                        w_item.kind         = KIND_RECORD;
                        w_item.record_index = r_idx;
                        w_item.name_offset  = r_name_start;
                        w_item.record_type  = r_type;
                        w_item.record_class = r_class;
                        w_item.time_to_live = r_ttl;
                        w_item.data_offset  = r_pos[11:0] + 12'd1 - r_len[11:0];
                        w_item.data_length  = r_len;
                        n_rec_left          = r_rec_left - 18'd1;
                        n_idx               = r_idx + 18'd1;
                        w_begin             = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (w_begin) begin
                if (n_q_left != '0 || n_rec_left != '0) begin
                    n_phase      = PH_NAME;
                    n_name_start = r_pos[11:0] + 12'd1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            n_pos = r_pos + POS_W'(1);
        end

        if (r_in_last) begin
            w_end_vld     = 1'b1;
            w_end.kind    = KIND_END;
            w_end.is_last = 1'b1;
            if (n_err != ST_OK) begin
                w_end.status = n_err;
            end else if (n_pos < POS_W'(HEADER_BYTES)) begin
                w_end.status = ST_SHORT_HDR;
            end else if (n_phase != PH_DONE) begin
                w_end.status = ST_TRUNCATED;
            end else begin
                w_end.status = ST_OK;
            end
            // message done: back to the start state
            n_pos        = '0;
            n_phase      = PH_HEADER;
            n_q_left     = '0;
            n_rec_left   = '0;
            n_skip       = '0;
            n_fbi        = '0;
            n_type       = '0;
            n_class      = '0;
            n_ttl        = '0;
            n_len        = '0;
            n_name_start = '0;
            n_idx        = '0;
            n_err        = ST_OK;
        end
    end

    assign w_first  = w_item_vld ? w_item : w_end;
    assign w_push_n = w_advance ? ({1'b0, w_item_vld} + {1'b0, w_end_vld}) : 2'd0;
    assign n_cnt    = r_cnt + QCNT_W'(w_push_n) - QCNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_pos        <= '0;
            r_phase      <= PH_HEADER;
            r_q_left     <= '0;
            r_rec_left   <= '0;
            r_skip       <= '0;
            r_fbi        <= '0;
            r_type       <= '0;
            r_class      <= '0;
            r_ttl        <= '0;
            r_len        <= '0;
            r_name_start <= '0;
            r_idx        <= '0;
            r_err        <= ST_OK;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_cnt        <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (w_advance) begin
                r_pos        <= n_pos;
                r_phase      <= n_phase;
                r_q_left     <= n_q_left;
                r_rec_left   <= n_rec_left;
                r_skip       <= n_skip;
                r_fbi        <= n_fbi;
                r_type       <= n_type;
                r_class      <= n_class;
                r_ttl        <= n_ttl;
                r_len        <= n_len;
                r_name_start <= n_name_start;
                r_idx        <= n_idx;
                r_err        <= n_err;
                r_wr_ptr     <= r_wr_ptr + QPTR_W'(w_push_n);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (w_push_n != 2'd0) begin
            r_q_mem[r_wr_ptr] <= w_first;
        end
        if (w_push_n == 2'd2) begin
            r_q_mem[r_wr_ptr + QPTR_W'(1)] <= w_end;
        end
    end

    t_result w_head;
    assign w_head          = r_q_mem[r_rd_ptr];
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tuser  = w_head.kind;
    assign o_m_axis_tlast  = w_head.is_last;
    assign o_m_axis_tdata  = {4'h0, w_head.status, w_head.data_length, w_head.data_offset,
                              w_head.time_to_live, w_head.record_class, w_head.record_type,
                              w_head.name_offset, w_head.record_index};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("output queue count beyond depth");

    a_two_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_n == 2'd2) |-> r_in_last)
        else $error("two results from a byte that is not the last");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |=> (r_phase == PH_HEADER && r_pos == '0 && r_err == ST_OK))
        else $error("walker not back at header after message end");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_MESSAGE_BYTES))
        else $error("byte position ran past the message limit");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_n != 2'd0) |-> (r_cnt <= QCNT_W'(QDEPTH - 2)))
        else $error("result written into a full queue");

endmodule
